// ----- sv/assert_macros.svh -----
// Assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property, held off during reset.
`define VN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("vn check failed");

// Check a property at every edge, reset included.
`define VN_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("vn check failed");

`endif

// ----- sv/vn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;
   localparam int CompWidth  = 24;
   localparam int SumWidth   = 48;
   localparam int SqrtSteps  = 24;
   localparam int FracShift  = 14;
   localparam int RemWidth   = CompWidth + FracShift;
   localparam int QuotWidth  = FracShift + 1;
   localparam int OutWidth   = 16;
   localparam logic [QuotWidth-1:0] UnitOne = QuotWidth'(16384);

   typedef struct packed {
      logic [2:0]                 sign;
      logic [2:0][CompWidth-1:0]  mag;
   } side_type;
endpackage
`default_nettype wire

// ----- sv/vn_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vn_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       valid_in,
   input  wire logic [vn_pkg::SumWidth-1:0] sum_in,
   input  wire vn_pkg::side_type           side_in,
   output logic                            valid_out,
   output logic [vn_pkg::CompWidth-1:0]    len_out,
   output vn_pkg::side_type                side_out
);
   localparam int N = vn_pkg::SqrtSteps;
   localparam int W = vn_pkg::SumWidth;

   logic             vld_s [N+1];
   logic [W-1:0]     n_s   [N+1];
   logic [W-1:0]     res_s [N+1];
   vn_pkg::side_type side_s[N+1];

   assign vld_s[0]  = valid_in;
   assign n_s[0]    = sum_in;
   assign res_s[0]  = '0;
   assign side_s[0] = side_in;

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam logic [W-1:0] StepBit = W'(1) << (W - 2 - 2 * k);
      logic             vld_ff;
      logic [W-1:0]     n_ff, n_in, res_ff, res_in, trial;
      vn_pkg::side_type side_ff;

      always_comb begin
         trial = res_s[k] + StepBit;
         if (n_s[k] >= trial) begin
            n_in   = n_s[k] - trial;
            res_in = (res_s[k] >> 1) + StepBit;
         end else begin
            n_in   = n_s[k];
            res_in = res_s[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_s[k];
         end
      end

      always_ff @(posedge clock) begin
         n_ff    <= n_in;
         res_ff  <= res_in;
         side_ff <= side_s[k];
      end

      assign vld_s[k+1]  = vld_ff;
      assign n_s[k+1]    = n_ff;
      assign res_s[k+1]  = res_ff;
      assign side_s[k+1] = side_ff;
   end

   assign valid_out = vld_s[N];
   assign len_out   = res_s[N][vn_pkg::CompWidth-1:0];
   assign side_out  = side_s[N];
endmodule
`default_nettype wire

// ----- sv/vn_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vn_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 valid_in,
   input  wire logic [vn_pkg::CompWidth-1:0]         len_in,
   input  wire vn_pkg::side_type                     side_in,
   output logic                                      valid_out,
   output logic                                      zero_out,
   output logic [2:0]                                sign_out,
   output logic [2:0][vn_pkg::QuotWidth-1:0]         quot_out
);
   localparam int N  = vn_pkg::QuotWidth;
   localparam int RW = vn_pkg::RemWidth;

   logic                        vld_s [N+1];
   logic                        zero_s[N+1];
   logic [2:0]                  sign_s[N+1];
   logic [vn_pkg::CompWidth-1:0] len_s[N+1];
   logic [2:0][RW-1:0]          rem_s [N+1];
   logic [2:0][N-1:0]           quot_s[N+1];

   assign vld_s[0]  = valid_in;
   assign zero_s[0] = (len_in == '0);
   assign sign_s[0] = side_in.sign;
   assign len_s[0]  = len_in;
   assign quot_s[0] = '0;
   for (genvar c = 0; c < 3; c++) begin : g_init
      assign rem_s[0][c] = {side_in.mag[c], {vn_pkg::FracShift{1'b0}}};
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam int Sh = N - 1 - k;
      logic                         vld_ff, zero_ff;
      logic [2:0]                   sign_ff;
      logic [vn_pkg::CompWidth-1:0] len_ff;
      logic [2:0][RW-1:0]           rem_ff, rem_in;
      logic [2:0][N-1:0]            quot_ff, quot_in;
      logic [RW-1:0]                dvs;

      always_comb begin
         dvs = RW'(len_s[k]) << Sh;
         for (int c = 0; c < 3; c++) begin
            quot_in[c] = quot_s[k][c];
            if (rem_s[k][c] >= dvs) begin
               rem_in[c]      = rem_s[k][c] - dvs;
               quot_in[c][Sh] = 1'b1;
            end else begin
               rem_in[c] = rem_s[k][c];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_s[k];
         end
      end

      always_ff @(posedge clock) begin
         zero_ff <= zero_s[k];
         sign_ff <= sign_s[k];
         len_ff  <= len_s[k];
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end

      assign vld_s[k+1]  = vld_ff;
      assign zero_s[k+1] = zero_ff;
      assign sign_s[k+1] = sign_ff;
      assign len_s[k+1]  = len_ff;
      assign rem_s[k+1]  = rem_ff;
      assign quot_s[k+1] = quot_ff;
   end

   assign valid_out = vld_s[N];
   assign zero_out  = zero_s[N];
   assign sign_out  = sign_s[N];
   assign quot_out  = quot_s[N];
endmodule
`default_nettype wire

// ----- sv/vector3_normalize.sv -----
// Accepted starts pass input registers, square root, divider, output register.
// Throughput: one transaction per cycle; busy is always low.
// Depth is set by the 24-stage square root and the 15-stage divider pipelines.
// Reset clears all stage valid bits; payload registers are not reset.
// The receiver cannot stall; each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module vector3_normalize (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [23:0] req_x_in,
   input  wire logic signed [23:0] req_y_in,
   input  wire logic signed [23:0] req_z_in,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_x_out,
   output logic signed [15:0]      rsp_y_out,
   output logic signed [15:0]      rsp_z_out,
   output logic                    rsp_zero_length
);
   localparam int CW = vn_pkg::CompWidth;
   localparam int SW = vn_pkg::SumWidth;
   localparam int QW = vn_pkg::QuotWidth;
   localparam int OW = vn_pkg::OutWidth;

   logic [2:0][CW-1:0] comp;
   logic               v1_ff, v2_ff, v3_ff;
   vn_pkg::side_type   side1_ff, side2_ff, side3_ff, side_sq;
   logic [2:0][SW-1:0] sq_ff;
   logic [SW-1:0]      sum_ff;
   logic               v_sq, v_dv, zero_dv;
   logic [CW-1:0]      len_sq;
   logic [2:0]         sign_dv;
   logic [2:0][QW-1:0] quot_dv;
   logic               rsp_valid_ff, zero_ff;
   logic [2:0][OW-1:0] out_ff, out_in;

   assign busy = 1'b0;
   assign comp = {req_z_in, req_y_in, req_x_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         side1_ff.sign[c] <= comp[c][CW-1];
         side1_ff.mag[c]  <= comp[c][CW-1] ? CW'(-comp[c]) : comp[c];
         sq_ff[c]         <= SW'(side1_ff.mag[c]) * SW'(side1_ff.mag[c]);
      end
      side2_ff <= side1_ff;
      sum_ff   <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      side3_ff <= side2_ff;
   end

   vn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v3_ff),
      .sum_in    (sum_ff),
      .side_in   (side3_ff),
      .valid_out (v_sq),
      .len_out   (len_sq),
      .side_out  (side_sq)
   );

   vn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v_sq),
      .len_in    (len_sq),
      .side_in   (side_sq),
      .valid_out (v_dv),
      .zero_out  (zero_dv),
      .sign_out  (sign_dv),
      .quot_out  (quot_dv)
   );

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [OW-1:0] mag16;
         mag16 = (quot_dv[c] > vn_pkg::UnitOne) ? OW'(vn_pkg::UnitOne) : OW'(quot_dv[c]);
         if (zero_dv) begin
            out_in[c] = '0;
         end else if (sign_dv[c]) begin
            out_in[c] = -mag16;
         end else begin
            out_in[c] = mag16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v_dv;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      zero_ff <= zero_dv;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_out       = out_ff[0];
   assign rsp_y_out       = out_ff[1];
   assign rsp_z_out       = out_ff[2];
   assign rsp_zero_length = zero_ff;
endmodule
`default_nettype wire

// ----- sv/vn_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vn_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic signed [15:0] rsp_x_out,
   input wire logic signed [15:0] rsp_y_out,
   input wire logic signed [15:0] rsp_z_out,
   input wire logic               rsp_zero_length
);
   `VN_ASSERT_ALWAYS(a_never_busy, clock, !busy)
   `VN_ASSERT(a_quiet_after_reset, clock, reset, $past(reset) |-> !rsp_valid)
   `VN_ASSERT(a_zero_clears, clock, reset, (rsp_valid && rsp_zero_length) |-> (rsp_x_out == 16'sd0 && rsp_y_out == 16'sd0 && rsp_z_out == 16'sd0))
   `VN_ASSERT(a_x_range, clock, reset, rsp_valid |-> (rsp_x_out <= 16'sd16384 && rsp_x_out >= -16'sd16384))
endmodule

bind vector3_normalize vn_checker u_vn_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_x_out       (rsp_x_out),
   .rsp_y_out       (rsp_y_out),
   .rsp_z_out       (rsp_z_out),
   .rsp_zero_length (rsp_zero_length)
);
`default_nettype wire
